// ===== hw/rtl/bcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants for the binomial coefficient unit.
// ----------------------------------------------------------------------------
package bcg_pkg;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ValueWidthDefault = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROUND,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_CHECK,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_NUM_DIV,
    ST_DEN_DIV,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/binomial_coefficient_gcd_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_coefficient_gcd_unit
// C(n, r) through gcd-reduced rounds on one shared add/subtract unit.
// ----------------------------------------------------------------------------
// Flow: for r above n the result is presented straight after the setup state;
// otherwise setup is followed by rounds of num*n, den*r (shift and add), Euclid
// steps for their gcd, and division of both by it, until r is zero.
// A round whose product overflows ends at its check and presents the result.
// Throughput: one request at a time; in_stall is high from acceptance until the
// result is taken. Synchronous active-low reset returns the sequencer to idle.
module binomial_coefficient_gcd_unit #(
  parameter int unsigned VALUE_WIDTH = bcg_pkg::ValueWidthDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bcg_pkg::FieldWidth-1:0]  in_n_value,
  input  wire logic [bcg_pkg::FieldWidth-1:0]  in_r_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [63:0]                          out_choose_result,
  output logic                                 out_overflow
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned FW = bcg_pkg::FieldWidth;
  localparam int unsigned CW = $clog2(W);

  bcg_pkg::state_t state_r, state_nxt;

  logic [FW-1:0] n_r, n_nxt, r_r, r_nxt;
  logic [W-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic [W-1:0]  np_r, np_nxt, dp_r, dp_nxt;
  logic [W-1:0]  op_r, op_nxt;      // multiplicand or divisor
  logic [W-1:0]  acc_r, acc_nxt;    // product or remainder
  logic [W-1:0]  quo_r, quo_nxt;    // dividend shifting into quotient
  logic [FW-1:0] mlt_r, mlt_nxt;    // multiplier bits, MSB first
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          mul_ovf_r, mul_ovf_nxt;

  // shared add/subtract unit
  logic          alu_sub;
  logic [W:0]    alu_a;
  logic [W:0]    alu_b;
  logic [W:0]    alu_y;
  logic          div_fits;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  quo_step;
  logic          mul_step_ovf;
  logic          last_mul;
  logic          last_div;
  logic [W-1:0]  all_ones;
  logic [W-1:0]  res_w;

  assign alu_sub = (state_r == bcg_pkg::ST_GCD_DIV) || (state_r == bcg_pkg::ST_NUM_DIV) ||
                   (state_r == bcg_pkg::ST_DEN_DIV);
  assign alu_a   = alu_sub ? {acc_r, quo_r[W-1]} : {acc_r, 1'b0};
  assign alu_b   = (alu_sub || mlt_r[FW-1]) ? {1'b0, op_r} : '0;
  assign alu_y   = alu_a + (alu_b ^ {(W+1){alu_sub}}) + {{W{1'b0}}, alu_sub};

  assign div_fits     = !alu_y[W];
  assign rem_step     = div_fits ? alu_y[W-1:0] : alu_a[W-1:0];
  assign quo_step     = {quo_r[W-2:0], div_fits};
  assign mul_step_ovf = acc_r[W-1] | alu_y[W];
  assign last_mul     = (cnt_r == CW'(FW - 1));
  assign last_div     = (cnt_r == CW'(W - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcg_pkg::ST_IDLE:     if (in_valid) state_nxt = bcg_pkg::ST_SETUP;
      bcg_pkg::ST_SETUP:    state_nxt = (r_r > n_r) ? bcg_pkg::ST_OUT : bcg_pkg::ST_ROUND;
      bcg_pkg::ST_ROUND:    state_nxt = (r_r == '0) ? bcg_pkg::ST_OUT : bcg_pkg::ST_MUL_NUM;
      bcg_pkg::ST_MUL_NUM:  if (last_mul) state_nxt = bcg_pkg::ST_MUL_DEN;
      bcg_pkg::ST_MUL_DEN:  if (last_mul) state_nxt = bcg_pkg::ST_CHECK;
      bcg_pkg::ST_CHECK:    state_nxt = mul_ovf_r ? bcg_pkg::ST_OUT : bcg_pkg::ST_GCD_DIV;
      bcg_pkg::ST_GCD_DIV:  if (last_div) state_nxt = bcg_pkg::ST_GCD_STEP;
      bcg_pkg::ST_GCD_STEP: state_nxt = (acc_r == '0) ? bcg_pkg::ST_NUM_DIV
                                                      : bcg_pkg::ST_GCD_DIV;
      bcg_pkg::ST_NUM_DIV:  if (last_div) state_nxt = bcg_pkg::ST_DEN_DIV;
      bcg_pkg::ST_DEN_DIV:  if (last_div) state_nxt = bcg_pkg::ST_ROUND;
      bcg_pkg::ST_OUT:      if (!out_stall) state_nxt = bcg_pkg::ST_IDLE;
      default:              state_nxt = bcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != bcg_pkg::ST_IDLE);
    out_valid = (state_r == bcg_pkg::ST_OUT);
  end

  always_comb begin
    n_nxt       = n_r;
    r_nxt       = r_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    np_nxt      = np_r;
    dp_nxt      = dp_r;
    op_nxt      = op_r;
    acc_nxt     = acc_r;
    quo_nxt     = quo_r;
    mlt_nxt     = mlt_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    mul_ovf_nxt = mul_ovf_r;
    unique case (state_r)
      bcg_pkg::ST_IDLE: begin
        if (in_valid) begin
          n_nxt = in_n_value;
          r_nxt = in_r_value;
        end
      end
      bcg_pkg::ST_SETUP: begin
        den_nxt = W'(1);
        ovf_nxt = 1'b0;
        if (r_r > n_r) begin
          num_nxt = '0;
        end else begin
          num_nxt = W'(1);
          // use the smaller of r and n - r
          if (n_r - r_r < r_r) r_nxt = n_r - r_r;
        end
      end
      bcg_pkg::ST_ROUND: begin
        acc_nxt     = '0;
        op_nxt      = num_r;
        mlt_nxt     = n_r;
        cnt_nxt     = '0;
        mul_ovf_nxt = 1'b0;
      end
      bcg_pkg::ST_MUL_NUM, bcg_pkg::ST_MUL_DEN: begin
        acc_nxt     = alu_y[W-1:0];
        mlt_nxt     = {mlt_r[FW-2:0], 1'b0};
        cnt_nxt     = cnt_r + CW'(1);
        mul_ovf_nxt = mul_ovf_r | mul_step_ovf;
        if (last_mul && state_r == bcg_pkg::ST_MUL_NUM) begin
          // hold the numerator product, start den * r
          np_nxt  = alu_y[W-1:0];
          acc_nxt = '0;
          op_nxt  = den_r;
          mlt_nxt = r_r;
          cnt_nxt = '0;
        end
      end
      bcg_pkg::ST_CHECK: begin
        if (mul_ovf_r) begin
          ovf_nxt = 1'b1;
        end else begin
          dp_nxt  = acc_r;
          quo_nxt = np_r;
          op_nxt  = acc_r;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      bcg_pkg::ST_GCD_DIV: begin
        acc_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CW'(1);
      end
      bcg_pkg::ST_GCD_STEP: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (acc_r == '0) begin
          // divisor is the gcd; keep it and divide the numerator
          quo_nxt = np_r;
        end else begin
          quo_nxt = op_r;
          op_nxt  = acc_r;
        end
      end
      bcg_pkg::ST_NUM_DIV: begin
        acc_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CW'(1);
        if (last_div) begin
          num_nxt = quo_step;
          quo_nxt = dp_r;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      bcg_pkg::ST_DEN_DIV: begin
        acc_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CW'(1);
        if (last_div) begin
          den_nxt = quo_step;
          n_nxt   = n_r - FW'(1);
          r_nxt   = r_r - FW'(1);
        end
      end
      bcg_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bcg_pkg::ST_IDLE;
      n_r       <= '0;
      r_r       <= '0;
      num_r     <= '0;
      den_r     <= '0;
      np_r      <= '0;
      dp_r      <= '0;
      op_r      <= '0;
      acc_r     <= '0;
      quo_r     <= '0;
      mlt_r     <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      mul_ovf_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      r_r       <= r_nxt;
      num_r     <= num_nxt;
      den_r     <= den_nxt;
      np_r      <= np_nxt;
      dp_r      <= dp_nxt;
      op_r      <= op_nxt;
      acc_r     <= acc_nxt;
      quo_r     <= quo_nxt;
      mlt_r     <= mlt_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      mul_ovf_r <= mul_ovf_nxt;
    end
  end

  assign all_ones = '1;
  assign res_w = ovf_r ? all_ones : num_r;
  assign out_choose_result = 64'(res_w);
  assign out_overflow = ovf_r;
endmodule
`default_nettype wire

// ===== sim/tb_binomial_coefficient_gcd_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient_gcd_unit
// Self-checking bench for the C(n, r) unit. A directed set covers the field
// extremes, r above n, r zero or equal to n, exact fits near the 64-bit limit
// and product overflow. A random set follows, half of it small n with random
// r, the rest large n or fully random pairs. Each accepted request is scored
// against a behavioral model of the gcd-reduced rounds. Both handshakes see
// random gaps and stalls, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_gcd_unit;

  typedef struct packed {
    logic [bcg_pkg::FieldWidth-1:0] n_value;
    logic [bcg_pkg::FieldWidth-1:0] r_value;
  } choose_req_t;

  typedef struct packed {
    logic [63:0] choose_result;
    logic        overflow;
  } choose_rsp_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [bcg_pkg::FieldWidth-1:0] in_n_value;
  logic [bcg_pkg::FieldWidth-1:0] in_r_value;
  logic                           out_valid;
  logic                           out_stall;
  logic [63:0]                    out_choose_result;
  logic                           out_overflow;

  choose_req_t pending_reqs[$];
  choose_rsp_t expected_coeffs[$];
  logic        req_taken;
  int          gap_left;
  int          hold_left;
  int          backpressure_left;
  logic        backpressure_done;
  int          reqs_accepted;
  int          coeffs_checked;
  int          overflow_seen;
  int          mismatches;

  binomial_coefficient_gcd_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_n_value       (in_n_value),
    .in_r_value       (in_r_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_choose_result(out_choose_result),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic choose_rsp_t compute_choose(logic [15:0] n_in, logic [15:0] r_in);
    longint unsigned n;
    longint unsigned r;
    longint unsigned num;
    longint unsigned den;
    longint unsigned g;
    longint unsigned lim;
    choose_rsp_t rsp;
    n = n_in;
    r = r_in;
    num = 1;
    den = 1;
    lim = '1;
    rsp.overflow = 1'b0;
    if (r > n) begin
      rsp.choose_result = '0;
      return rsp;
    end
    if (n - r < r) r = n - r;
    while (r != 0) begin
      if (num > lim / n || den > lim / r) begin
        rsp.overflow = 1'b1;
        break;
      end
      num = num * n;
      den = den * r;
      g = gcd64(num, den);
      if (g == 0) g = 1;
      num = num / g;
      den = den / g;
      n--;
      r--;
    end
    rsp.choose_result = rsp.overflow ? lim : num;
    return rsp;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void queue_req(int n, int r);
    choose_req_t req;
    req.n_value = n[15:0];
    req.r_value = r[15:0];
    pending_reqs = {pending_reqs, req};
  endfunction

  // Accept requests and queue their expected coefficients
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_coeffs = {expected_coeffs, compute_choose(in_n_value, in_r_value)};
        reqs_accepted <= reqs_accepted + 1;
      end
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !req_taken) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        choose_req_t req;
        req = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        in_n_value <= req.n_value;
        in_r_value <= req.r_value;
        // run a stretch back to back in the middle of the test
        gap_left <= (reqs_accepted > 40 && reqs_accepted < 60) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (!backpressure_done && reqs_accepted == 20) begin
        backpressure_done <= 1'b1;
        backpressure_left <= 3000;
        out_stall <= 1'b1;
      end else if (backpressure_left > 0) begin
        backpressure_left <= backpressure_left - 1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        hold_left <= (reqs_accepted > 40 && reqs_accepted < 60) ? 0 : pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Score results
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_coeffs.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("ERROR: unexpected result %0h ovf %0b", out_choose_result, out_overflow);
      end else begin
        choose_rsp_t exp_rsp;
        exp_rsp = expected_coeffs.pop_front();
        coeffs_checked <= coeffs_checked + 1;
        if (out_overflow) overflow_seen <= overflow_seen + 1;
        if (out_choose_result !== exp_rsp.choose_result ||
            out_overflow !== exp_rsp.overflow) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: result exp %0h ovf %0b, got %0h ovf %0b",
                     exp_rsp.choose_result, exp_rsp.overflow,
                     out_choose_result, out_overflow);
        end
      end
    end
  end

  initial begin
    int n;
    int r;
    int mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_n_value = '0;
    in_r_value = '0;
    out_stall = 1'b0;
    gap_left = 0;
    hold_left = 0;
    backpressure_left = 0;
    backpressure_done = 1'b0;
    reqs_accepted = 0;
    coeffs_checked = 0;
    overflow_seen = 0;
    mismatches = 0;
    req_taken = 1'b0;

    // directed set
    queue_req(0, 0);
    queue_req(65535, 0);
    queue_req(65535, 65535);
    queue_req(0, 65535);
    queue_req(5, 7);
    queue_req(1, 1);
    queue_req(10, 3);
    queue_req(10, 7);
    queue_req(65535, 1);
    queue_req(65535, 2);
    queue_req(65535, 65534);
    queue_req(65535, 3);
    queue_req(65535, 32767);
    queue_req(62, 31);
    queue_req(66, 33);
    queue_req(67, 33);
    queue_req(68, 34);
    queue_req(100, 50);
    queue_req(30000, 7);
    queue_req(43690, 21845);
    queue_req(21845, 43690);
    queue_req(52, 26);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 80; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        n = $urandom_range(0, 70);
        r = $urandom_range(0, n + 3);
      end else if (mode < 7) begin
        n = $urandom_range(0, 65535);
        r = $urandom_range(0, 1) ? $urandom_range(0, 4) : n - $urandom_range(0, 4);
        if (r < 0) r = 0;
      end else begin
        n = $urandom_range(0, 65535);
        r = $urandom_range(0, 65535);
      end
      queue_req(n, r);
    end

    while (pending_reqs.size() != 0 || in_valid || expected_coeffs.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Checked %0d coefficients from %0d requests, %0d of them saturated.",
             coeffs_checked, reqs_accepted, overflow_seen);
    if (mismatches == 0 && expected_coeffs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("Timeout with %0d results outstanding", expected_coeffs.size());
    $display("simulation failed");
    $finish;
  end
endmodule
